// ----- rtl/core/env_sensor_compensation_macros.svh -----
// Assertion macros used by the compensation RTL.
// Included by env_sensor_compensation, which checks its own pipeline behavior.
`ifndef ENV_SENSOR_COMPENSATION_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_MACROS_SVH

// Implication checked in the same cycle, disabled during reset.
`define ESC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, disabled during reset.
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/esc_pkg.sv -----
// Shared constants and types for the sensor compensation pipeline.
// No dependencies; used by the top level and the testbench.
package esc_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int COEF48_W   = 48;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TEMP       = 3'd0,
        CFG_PRESS_LOW  = 3'd1,
        CFG_PRESS_MID  = 3'd2,
        CFG_PRESS_HIGH = 3'd3,
        CFG_HUM        = 3'd4
    } cfg_idx_t;

    localparam logic [DATA_W-1:0] P_OFFSET    = 32'd64000;
    localparam logic [DATA_W-1:0] P_FULL      = 32'd1048576;
    localparam logic [DATA_W-1:0] P_SCALE     = 32'd3125;
    localparam logic [DATA_W-1:0] P_ONE       = 32'd32768;
    localparam logic [DATA_W-1:0] H_T_OFFSET  = 32'd76800;
    localparam logic [DATA_W-1:0] H_MAX       = 32'd419430400;
    localparam logic [DATA_W-1:0] H_F_OFFSET  = 32'd2097152;
    localparam logic [DATA_W-1:0] H_ROUND_S   = 32'd16384;
    localparam logic [DATA_W-1:0] H_E_OFFSET  = 32'd32768;
    localparam logic [DATA_W-1:0] H_ROUND_G   = 32'd8192;
    localparam logic [DATA_W-1:0] T_ROUND     = 32'd128;
    localparam logic [16:0]       HUM_MAX_Q10 = 17'd102400;

endpackage

// ----- rtl/core/env_sensor_compensation.sv -----
// Environmental sensor compensation: raw pressure, temperature and humidity
// readings in, temperature in 0.01 degC, pressure in Pa and humidity in Q7.10 out.
// Depends on esc_pkg, esc_div and env_sensor_compensation_macros.svh.
//
// One reading set is accepted every cycle while the pipeline advances and
// passes through ten stages of temperature and pressure arithmetic, a 32-stage
// divider that produces one quotient bit per stage, and three stages of pressure
// correction. Humidity is computed alongside and delayed to line up. The
// whole pipeline advances together; it freezes only while a result sits at
// the output and the downstream side is not ready. Coefficients are read
// live from the configuration registers and must be written while idle.
`include "env_sensor_compensation_macros.svh"

module env_sensor_compensation (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [esc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [esc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // raw_pressure[19:0], raw_temperature[39:20], raw_humidity[55:40]
    input  logic [55:0]                       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // temperature_centi[31:0], pressure_pa[63:32], humidity_q10[80:64], zero fill
    output logic [87:0]                       m_axis_tdata
);

    localparam int DW      = esc_pkg::DATA_W;
    localparam int PIPE    = DW + 13;
    localparam int HUM_DLY = DW - 1;

    function automatic logic [DW-1:0] asr(input logic [DW-1:0] v, input int unsigned n);
        asr = $unsigned($signed(v) >>> n);
    endfunction

    function automatic logic [DW-1:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [DW-1:0] sx12(input logic [11:0] v);
        sx12 = {{20{v[11]}}, v};
    endfunction

    function automatic logic [DW-1:0] sx8(input logic [7:0] v);
        sx8 = {{24{v[7]}}, v};
    endfunction

    // Configuration registers.
    logic [esc_pkg::COEF48_W-1:0]   temp_c_reg;
    logic [esc_pkg::COEF48_W-1:0]   press_lo_reg;
    logic [esc_pkg::COEF48_W-1:0]   press_mid_reg;
    logic [esc_pkg::COEF48_W-1:0]   press_hi_reg;
    logic [esc_pkg::CFG_DATA_W-1:0] hum_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_c_reg    <= '0;
            press_lo_reg  <= '0;
            press_mid_reg <= '0;
            press_hi_reg  <= '0;
            hum_c_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                esc_pkg::CFG_TEMP:       temp_c_reg    <= cfg_data[esc_pkg::COEF48_W-1:0];
                esc_pkg::CFG_PRESS_LOW:  press_lo_reg  <= cfg_data[esc_pkg::COEF48_W-1:0];
                esc_pkg::CFG_PRESS_MID:  press_mid_reg <= cfg_data[esc_pkg::COEF48_W-1:0];
                esc_pkg::CFG_PRESS_HIGH: press_hi_reg  <= cfg_data[esc_pkg::COEF48_W-1:0];
                esc_pkg::CFG_HUM:        hum_c_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [DW-1:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [DW-1:0] h1, h2, h3, h4, h5, h6;

    assign t1 = {16'b0, temp_c_reg[15:0]};
    assign t2 = sx16(temp_c_reg[31:16]);
    assign t3 = sx16(temp_c_reg[47:32]);
    assign p1 = {16'b0, press_lo_reg[15:0]};
    assign p2 = sx16(press_lo_reg[31:16]);
    assign p3 = sx16(press_lo_reg[47:32]);
    assign p4 = sx16(press_mid_reg[15:0]);
    assign p5 = sx16(press_mid_reg[31:16]);
    assign p6 = sx16(press_mid_reg[47:32]);
    assign p7 = sx16(press_hi_reg[15:0]);
    assign p8 = sx16(press_hi_reg[31:16]);
    assign p9 = sx16(press_hi_reg[47:32]);
    assign h1 = {24'b0, hum_c_reg[7:0]};
    assign h2 = sx16(hum_c_reg[23:8]);
    assign h3 = {24'b0, hum_c_reg[31:24]};
    assign h4 = sx12(hum_c_reg[43:32]);
    assign h5 = sx12(hum_c_reg[55:44]);
    assign h6 = sx8(hum_c_reg[63:56]);

    // Pipeline control: everything moves unless a result is stuck at the output.
    logic [PIPE:1] vld_reg;
    logic          adv;

    assign adv           = !vld_reg[PIPE] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[PIPE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE-1:1], s_axis_tvalid};
        end
    end

    logic [19:0] raw_p, raw_t;
    logic [15:0] raw_h;

    assign raw_p = s_axis_tdata[19:0];
    assign raw_t = s_axis_tdata[39:20];
    assign raw_h = s_axis_tdata[55:40];

    // Front stages: temperature, pressure operands, humidity.
    logic [DW-1:0] ta1_reg, d1_reg, m1_2_reg, dd2_reg, at3_reg, m2_3_reg, fine4_reg;
    logic [DW-1:0] temp5_reg, pa5_reg, hx5_reg;
    logic [DW-1:0] qq6_reg, ap5_6_reg, ap2_6_reg, temp6_reg, hp6_reg, hc0_6_reg, he0_6_reg;
    logic [DW-1:0] b1_7_reg, c1_7_reg, ap5_7_reg, ap2_7_reg, temp7_reg, hs7_reg, hc7_reg;
    logic [DW-1:0] he7_reg, pb8_reg, ps8_reg, temp8_reg, hce8_reg, hs8_reg;
    logic [DW-1:0] dm9_reg, pu9_reg, temp9_reg, hfh9_reg, hs9_reg;
    logic [DW-1:0] den10_reg, num10_reg, temp10_reg, hg10_reg, hs10_reg;
    logic [DW-1:0] hx11_reg, hx12_reg, hqq12_reg, hx13_reg, hm13_reg;
    logic [16:0]   hum14_reg;
    logic [19:0]   adcp1_reg, adcp2_reg, adcp3_reg, adcp4_reg, adcp5_reg;
    logic [19:0]   adcp6_reg, adcp7_reg, adcp8_reg;
    logic [15:0]   adch1_reg, adch2_reg, adch3_reg, adch4_reg, adch5_reg, adch6_reg;
    logic [DW-1:0] q5, hq11, hv13;

    assign q5   = asr(pa5_reg, 2);
    assign hq11 = asr(hx11_reg, 15);
    assign hv13 = hx13_reg - asr(hm13_reg, 4);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ta1_reg   <= {15'b0, raw_t[19:3]} - (t1 << 1);
            d1_reg    <= {16'b0, raw_t[19:4]} - t1;
            adcp1_reg <= raw_p;
            adch1_reg <= raw_h;

            m1_2_reg  <= ta1_reg * t2;
            dd2_reg   <= d1_reg * d1_reg;
            adcp2_reg <= adcp1_reg;
            adch2_reg <= adch1_reg;

            at3_reg   <= asr(m1_2_reg, 11);
            m2_3_reg  <= asr(dd2_reg, 12) * t3;
            adcp3_reg <= adcp2_reg;
            adch3_reg <= adch2_reg;

            fine4_reg <= at3_reg + asr(m2_3_reg, 14);
            adcp4_reg <= adcp3_reg;
            adch4_reg <= adch3_reg;

            temp5_reg <= asr((fine4_reg << 2) + fine4_reg + esc_pkg::T_ROUND, 8);
            pa5_reg   <= asr(fine4_reg, 1) - esc_pkg::P_OFFSET;
            hx5_reg   <= fine4_reg - esc_pkg::H_T_OFFSET;
            adcp5_reg <= adcp4_reg;
            adch5_reg <= adch4_reg;

            qq6_reg   <= q5 * q5;
            ap5_6_reg <= pa5_reg * p5;
            ap2_6_reg <= p2 * pa5_reg;
            temp6_reg <= temp5_reg;
            adcp6_reg <= adcp5_reg;
            hp6_reg   <= h5 * hx5_reg;
            hc0_6_reg <= hx5_reg * h6;
            he0_6_reg <= hx5_reg * h3;
            adch6_reg <= adch5_reg;

            b1_7_reg  <= asr(qq6_reg, 11) * p6;
            c1_7_reg  <= p3 * asr(qq6_reg, 13);
            ap5_7_reg <= ap5_6_reg;
            ap2_7_reg <= ap2_6_reg;
            temp7_reg <= temp6_reg;
            adcp7_reg <= adcp6_reg;
            hs7_reg   <= asr({2'b0, adch6_reg, 14'b0} - (h4 << 20) - hp6_reg
                             + esc_pkg::H_ROUND_S, 15);
            hc7_reg   <= asr(hc0_6_reg, 10);
            he7_reg   <= asr(he0_6_reg, 11) + esc_pkg::H_E_OFFSET;

            pb8_reg   <= asr(b1_7_reg + (ap5_7_reg << 1), 2) + (p4 << 16);
            ps8_reg   <= esc_pkg::P_ONE
                         + asr(asr(c1_7_reg, 3) + asr(ap2_7_reg, 1), 18);
            temp8_reg <= temp7_reg;
            adcp8_reg <= adcp7_reg;
            hce8_reg  <= hc7_reg * he7_reg;
            hs8_reg   <= hs7_reg;

            dm9_reg   <= ps8_reg * p1;
            pu9_reg   <= (esc_pkg::P_FULL - {12'b0, adcp8_reg}) - asr(pb8_reg, 12);
            temp9_reg <= temp8_reg;
            hfh9_reg  <= (asr(hce8_reg, 10) + esc_pkg::H_F_OFFSET) * h2;
            hs9_reg   <= hs8_reg;

            den10_reg  <= asr(dm9_reg, 15);
            num10_reg  <= pu9_reg * esc_pkg::P_SCALE;
            temp10_reg <= temp9_reg;
            hg10_reg   <= asr(hfh9_reg + esc_pkg::H_ROUND_G, 14);
            hs10_reg   <= hs9_reg;

            hx11_reg  <= hs10_reg * hg10_reg;

            hx12_reg  <= hx11_reg;
            hqq12_reg <= hq11 * hq11;

            hx13_reg  <= hx12_reg;
            hm13_reg  <= asr(hqq12_reg, 7) * h1;

            // Clamp to 0..100 %RH before dropping the 12 fraction bits.
            if (hv13[DW-1])
                hum14_reg <= '0;
            else if (hv13 > esc_pkg::H_MAX)
                hum14_reg <= esc_pkg::H_MAX[28:12];
            else
                hum14_reg <= hv13[28:12];
        end
    end

    logic [16:0] hum_dly_reg [1:HUM_DLY];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hum_dly_reg[1] <= hum14_reg;
            for (int k = 2; k <= HUM_DLY; k++)
            begin
                hum_dly_reg[k] <= hum_dly_reg[k-1];
            end
        end
    end

    // Division. A dividend with its top bit set is divided unshifted and the
    // quotient doubled afterwards.
    logic          div_big, div_zero;
    logic [DW-1:0] div_dividend, div_quo;
    logic [DW+1:0] div_side_out;

    assign div_big      = num10_reg[DW-1];
    assign div_zero     = (den10_reg == '0);
    assign div_dividend = div_big ? num10_reg : (num10_reg << 1);

    esc_div #(
        .W      (DW),
        .SIDE_W (DW + 2)
    ) u_div (
        .clk      (clk),
        .en       (adv),
        .dividend (div_dividend),
        .divisor  (den10_reg),
        .side_in  ({temp10_reg, div_zero, div_big}),
        .quotient (div_quo),
        .side_out (div_side_out)
    );

    logic [DW-1:0] pr42;
    logic [DW-1:0] pr43_reg, sq43_reg, pm43_reg, temp43_reg;
    logic [DW-1:0] pr44_reg, m44_reg, bb44_reg, temp44_reg;
    logic [DW-1:0] pres45_reg, temp45_reg;
    logic          dz43_reg, dz44_reg;

    assign pr42 = div_side_out[0] ? (div_quo << 1) : div_quo;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr43_reg   <= pr42;
            sq43_reg   <= (pr42 >> 3) * (pr42 >> 3);
            pm43_reg   <= (pr42 >> 2) * p8;
            temp43_reg <= div_side_out[DW+1:2];
            dz43_reg   <= div_side_out[1];

            pr44_reg   <= pr43_reg;
            m44_reg    <= p9 * (sq43_reg >> 13);
            bb44_reg   <= asr(pm43_reg, 13);
            temp44_reg <= temp43_reg;
            dz44_reg   <= dz43_reg;

            temp45_reg <= temp44_reg;
            if (dz44_reg)
                pres45_reg <= '0;
            else
                pres45_reg <= pr44_reg + asr(asr(m44_reg, 12) + bb44_reg + p7, 4);
        end
    end

    assign m_axis_tdata = {7'b0, hum_dly_reg[HUM_DLY], pres45_reg, temp45_reg};

    `ESC_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")
    `ESC_ASSERT_NEXT(a_accept_enters, clk, rst_n, s_axis_tvalid && s_axis_tready, vld_reg[1], "accepted transfer did not enter the pipeline")
    `ESC_ASSERT_NEXT(a_frozen_on_stall, clk, rst_n, !adv, $stable(vld_reg), "pipeline moved during a stall")
    `ESC_ASSERT_NOW(a_hum_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[80:64] <= esc_pkg::HUM_MAX_Q10, "humidity above full scale")

endmodule

// ----- rtl/core/esc_div.sv -----
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Uses no package items; instantiated by env_sensor_compensation.
module esc_div #(
    parameter int W      = 32,
    parameter int SIDE_W = 34
) (
    input  logic              clk,
    input  logic              en,
    input  logic [W-1:0]      dividend,
    input  logic [W-1:0]      divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic [W-1:0]      quotient,
    output logic [SIDE_W-1:0] side_out
);

    logic [W-1:0]      rem_reg  [1:W-1];
    logic [W-1:0]      den_reg  [1:W-1];
    logic [W-1:0]      dq_reg   [1:W];
    logic [SIDE_W-1:0] side_reg [1:W];

    for (genvar i = 0; i < W; i++) begin : g_stage
        logic [W-1:0]      rem_p;
        logic [W-1:0]      den_p;
        logic [W-1:0]      dq_p;
        logic [SIDE_W-1:0] side_p;
        logic [W:0]        trial;
        logic [W-1:0]      rem_next;
        logic [W-1:0]      dq_next;

        if (i == 0) begin : g_first
            assign rem_p  = '0;
            assign den_p  = divisor;
            assign dq_p   = dividend;
            assign side_p = side_in;
        end
        else begin : g_later
            assign rem_p  = rem_reg[i];
            assign den_p  = den_reg[i];
            assign dq_p   = dq_reg[i];
            assign side_p = side_reg[i];
        end

        // The dividend shifts out at the top while quotient bits fill in below.
        assign trial = {rem_p, dq_p[W-1]};

        always_comb
        begin
            if (trial >= {1'b0, den_p})
            begin
                rem_next = W'(trial - {1'b0, den_p});
                dq_next  = {dq_p[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                dq_next  = {dq_p[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dq_reg[i+1]   <= dq_next;
                side_reg[i+1] <= side_p;
            end
        end

        if (i < W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1] <= rem_next;
                    den_reg[i+1] <= den_p;
                end
            end
        end
    end

    assign quotient = dq_reg[W];
    assign side_out = side_reg[W];

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for env_sensor_compensation: streams raw reading sets
// and checks every result against a local integer predictor or a known value.
// Depends on esc_pkg and the env_sensor_compensation RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;
    // Indexes past the last register; writes there must be dropped.
    localparam logic [esc_pkg::CFG_ADDR_W-1:0] CFG_UNUSED_A = 3'd5;
    localparam logic [esc_pkg::CFG_ADDR_W-1:0] CFG_UNUSED_B = 3'd7;

    typedef struct packed {
        logic [31:0] temp_centi;
        logic [31:0] press_pa;
        logic [16:0] hum_q10;
    } reading_t;

    typedef struct {
        logic [19:0] raw_p;
        logic [19:0] raw_t;
        logic [15:0] raw_h;
        bit          typed;
        reading_t    known;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [esc_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [esc_pkg::CFG_DATA_W-1:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;

    env_sensor_compensation dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    logic [63:0] coeff_regs [5];
    reading_t    expected_readings [$];
    int          mismatch_count;
    int          idle_cycles;
    int          stall_left;
    bit          rx_quiet;
    bit          tx_quiet;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] asr(logic [31:0] v, int n);
        logic signed [31:0] s;
        s = v;
        return s >>> n;
    endfunction

    function automatic logic [31:0] sext(logic [63:0] v, int bits);
        logic signed [63:0] s;
        s = v << (64 - bits);
        s = s >>> (64 - bits);
        return s[31:0];
    endfunction

    function automatic reading_t compensate(logic [19:0] raw_p, logic [19:0] raw_t,
                                            logic [15:0] raw_h);
        logic [31:0] adc_p, adc_t, adc_h;
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [31:0] a, b, d, q, sq, fine, pres, x, s, c, e, f, g;
        logic [63:0] tc, pl, pm, ph, hc;
        reading_t r;
        adc_p = 32'(raw_p);
        adc_t = 32'(raw_t);
        adc_h = 32'(raw_h);
        tc = coeff_regs[esc_pkg::CFG_TEMP];
        pl = coeff_regs[esc_pkg::CFG_PRESS_LOW];
        pm = coeff_regs[esc_pkg::CFG_PRESS_MID];
        ph = coeff_regs[esc_pkg::CFG_PRESS_HIGH];
        hc = coeff_regs[esc_pkg::CFG_HUM];
        t1 = 32'(tc[15:0]);
        t2 = sext(tc >> 16, 16);
        t3 = sext(tc >> 32, 16);
        p1 = 32'(pl[15:0]);
        p2 = sext(pl >> 16, 16);
        p3 = sext(pl >> 32, 16);
        p4 = sext(pm, 16);
        p5 = sext(pm >> 16, 16);
        p6 = sext(pm >> 32, 16);
        p7 = sext(ph, 16);
        p8 = sext(ph >> 16, 16);
        p9 = sext(ph >> 32, 16);
        h1 = 32'(hc[7:0]);
        h2 = sext(hc >> 8, 16);
        h3 = 32'(hc[31:24]);
        h4 = sext(hc >> 32, 12);
        h5 = sext(hc >> 44, 12);
        h6 = sext(hc >> 56, 8);

        a = (adc_t >> 3) - (t1 << 1);
        a = asr(a * t2, 11);
        d = (adc_t >> 4) - t1;
        sq = d * d;
        b = asr(asr(sq, 12) * t3, 14);
        fine = a + b;
        r.temp_centi = asr(fine * 32'd5 + esc_pkg::T_ROUND, 8);

        a = asr(fine, 1) - esc_pkg::P_OFFSET;
        q = asr(a, 2);
        sq = q * q;
        b = asr(sq, 11) * p6;
        b = b + ((a * p5) << 1);
        b = asr(b, 2) + (p4 << 16);
        a = asr(asr(p3 * asr(sq, 13), 3) + asr(p2 * a, 1), 18);
        a = asr((esc_pkg::P_ONE + a) * p1, 15);
        if (a == 32'd0)
        begin
            pres = 32'd0;
        end
        else
        begin
            pres = ((esc_pkg::P_FULL - adc_p) - asr(b, 12)) * esc_pkg::P_SCALE;
            if (pres[31] == 1'b0)
                pres = (pres << 1) / a;
            else
                pres = (pres / a) * 32'd2;
            sq = (pres >> 3) * (pres >> 3);
            sq = sq >> 13;
            a = asr(p9 * sq, 12);
            b = asr((pres >> 2) * p8, 13);
            pres = pres + asr(a + b + p7, 4);
        end
        r.press_pa = pres;

        x = fine - esc_pkg::H_T_OFFSET;
        s = asr((adc_h << 14) - (h4 << 20) - (h5 * x) + esc_pkg::H_ROUND_S, 15);
        c = asr(x * h6, 10);
        e = asr(x * h3, 11) + esc_pkg::H_E_OFFSET;
        f = asr(c * e, 10) + esc_pkg::H_F_OFFSET;
        g = asr(f * h2 + esc_pkg::H_ROUND_G, 14);
        x = s * g;
        q = asr(x, 15);
        sq = q * q;
        x = x - asr(asr(sq, 7) * h1, 4);
        if (x[31])
            x = 32'd0;
        if (x > esc_pkg::H_MAX)
            x = esc_pkg::H_MAX;
        r.hum_q10 = x[28:12];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        mismatch_count++;
    endtask

    task automatic write_coeffs(logic [esc_pkg::CFG_ADDR_W-1:0] idx, logic [63:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        if (idx <= esc_pkg::CFG_HUM)
            coeff_regs[idx] = (idx < esc_pkg::CFG_HUM) ? (value & 64'hFFFF_FFFF_FFFF)
                                                       : value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drain the pipeline before coefficients may change.
    task automatic wait_idle();
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_reading(logic [19:0] raw_p, logic [19:0] raw_t, logic [15:0] raw_h,
                                bit typed, reading_t known);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {raw_h, raw_t, raw_p};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        expected_readings.push_back(typed ? known : compensate(raw_p, raw_t, raw_h));
        gap = 0;
        if (!tx_quiet && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic finish_burst();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [19:0] pick_raw20(logic [19:0] centre);
        if ($urandom_range(0, 3) == 0)
            return 20'($urandom_range(0, 20'hFFFFF));
        return centre + 20'($urandom_range(0, 8191)) - 20'd4096;
    endfunction

    task automatic random_burst(int n);
        reading_t none;
        logic [15:0] h;
        none = '0;
        for (int i = 0; i < n; i++)
        begin
            h = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                           : 16'($urandom_range(20000, 45000));
            send_reading(pick_raw20(20'd415148), pick_raw20(20'd519888), h, 1'b0, none);
        end
        finish_burst();
    endtask

    // Coefficient sets from a typical device calibration.
    localparam logic [63:0] TYP_TEMP  = {16'h0, 16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_PLOW  = {16'h0, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] TYP_PMID  = {16'h0, 16'hFFF9, 16'd140, 16'd2855};
    localparam logic [63:0] TYP_PHIGH = {16'h0, 16'd6000, 16'hC6F8, 16'd15500};
    localparam logic [63:0] TYP_HUM   = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

    task automatic load_typical();
        write_coeffs(esc_pkg::CFG_TEMP, TYP_TEMP);
        write_coeffs(esc_pkg::CFG_PRESS_LOW, TYP_PLOW);
        write_coeffs(esc_pkg::CFG_PRESS_MID, TYP_PMID);
        write_coeffs(esc_pkg::CFG_PRESS_HIGH, TYP_PHIGH);
        write_coeffs(esc_pkg::CFG_HUM, TYP_HUM);
    endtask

    function automatic logic [63:0] nudge(logic [63:0] base);
        logic [63:0] v;
        v = base;
        for (int k = 0; k < 4; k++)
            v[$urandom_range(0, 63)] ^= 1'b1;
        return v;
    endfunction

    stim_row_t directed_rows [$];

    function automatic stim_row_t row(logic [19:0] p, logic [19:0] t, logic [15:0] h,
                                      bit typed);
        stim_row_t r;
        r.raw_p = p;
        r.raw_t = t;
        r.raw_h = h;
        r.typed = typed;
        r.known = '0;
        return r;
    endfunction

    // Output side: consume results, randomize ready, watch for a hang.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            idle_cycles   <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_readings.size() == 0)
                begin
                    report_mismatch("unexpected transfer", m_axis_tdata[31:0], 32'd0);
                end
                else
                begin
                    reading_t want;
                    want = expected_readings.pop_front();
                    if (m_axis_tdata[31:0] !== want.temp_centi)
                        report_mismatch("temperature_centi", m_axis_tdata[31:0],
                                        want.temp_centi);
                    if (m_axis_tdata[63:32] !== want.press_pa)
                        report_mismatch("pressure_pa", m_axis_tdata[63:32], want.press_pa);
                    if (m_axis_tdata[80:64] !== want.hum_q10)
                        report_mismatch("humidity_q10", 32'(m_axis_tdata[80:64]),
                                        32'(want.hum_q10));
                end
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (stall_left > 0)
            begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!rx_quiet && $urandom_range(0, 4) == 0)
            begin
                stall_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = esc_pkg::CFG_TEMP;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        mismatch_count = 0;
        rx_quiet       = 1'b0;
        tx_quiet       = 1'b0;
        foreach (coeff_regs[i])
            coeff_regs[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // All coefficients are zero after reset, so every field reads zero;
        // this also covers the zero pressure divisor.
        directed_rows.push_back(row(20'd0, 20'd0, 16'd0, 1'b1));
        directed_rows.push_back(row(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1));
        directed_rows.push_back(row(20'hFFFFF, 20'd0, 16'd0, 1'b1));
        directed_rows.push_back(row(20'd0, 20'hFFFFF, 16'hFFFF, 1'b1));
        directed_rows.push_back(row(20'hAAAAA, 20'h55555, 16'hA5A5, 1'b1));
        // Rows below run with typical coefficients: extremes and the
        // humidity clamps at both ends.
        directed_rows.push_back(row(20'd415148, 20'd519888, 16'd30000, 1'b0));
        directed_rows.push_back(row(20'd0, 20'd519888, 16'd0, 1'b0));
        directed_rows.push_back(row(20'hFFFFF, 20'd519888, 16'hFFFF, 1'b0));
        directed_rows.push_back(row(20'd415148, 20'd0, 16'd30000, 1'b0));
        directed_rows.push_back(row(20'd415148, 20'hFFFFF, 16'd30000, 1'b0));
        directed_rows.push_back(row(20'd0, 20'd0, 16'd0, 1'b0));
        directed_rows.push_back(row(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0));
        directed_rows.push_back(row(20'd300000, 20'd400000, 16'd60000, 1'b0));

        tx_quiet = 1'b1;
        foreach (directed_rows[i])
        begin
            if (i == 5)
            begin
                finish_burst();
                wait_idle();
                load_typical();
                // Writes past the register file and stray high bits must do nothing.
                write_coeffs(CFG_UNUSED_A, 64'hFFFF_FFFF_FFFF_FFFF);
                write_coeffs(CFG_UNUSED_B, 64'h1234_5678_9ABC_DEF0);
                write_coeffs(esc_pkg::CFG_TEMP, TYP_TEMP | 64'hFFFF_0000_0000_0000);
                tx_quiet = 1'b0;
            end
            send_reading(directed_rows[i].raw_p, directed_rows[i].raw_t,
                         directed_rows[i].raw_h, directed_rows[i].typed,
                         directed_rows[i].known);
        end
        finish_burst();

        // Random phases, each preceded by loading a coefficient set.
        for (int ph = 0; ph < 7; ph++)
        begin
            wait_idle();
            case (ph)
                0: load_typical();
                1:
                begin
                    write_coeffs(esc_pkg::CFG_TEMP, nudge(TYP_TEMP));
                    write_coeffs(esc_pkg::CFG_PRESS_LOW, nudge(TYP_PLOW));
                    write_coeffs(esc_pkg::CFG_PRESS_MID, nudge(TYP_PMID));
                    write_coeffs(esc_pkg::CFG_PRESS_HIGH, nudge(TYP_PHIGH));
                    write_coeffs(esc_pkg::CFG_HUM, nudge(TYP_HUM));
                end
                2, 5:
                begin
                    write_coeffs(esc_pkg::CFG_TEMP, {$urandom, $urandom});
                    write_coeffs(esc_pkg::CFG_PRESS_LOW, {$urandom, $urandom});
                    write_coeffs(esc_pkg::CFG_PRESS_MID, {$urandom, $urandom});
                    write_coeffs(esc_pkg::CFG_PRESS_HIGH, {$urandom, $urandom});
                    write_coeffs(esc_pkg::CFG_HUM, {$urandom, $urandom});
                end
                3:
                begin
                    write_coeffs(esc_pkg::CFG_TEMP, '1);
                    write_coeffs(esc_pkg::CFG_PRESS_LOW, '1);
                    write_coeffs(esc_pkg::CFG_PRESS_MID, '1);
                    write_coeffs(esc_pkg::CFG_PRESS_HIGH, '1);
                    write_coeffs(esc_pkg::CFG_HUM, '1);
                end
                4:
                begin
                    // Typical set with P1 cleared: the divisor is always zero.
                    load_typical();
                    write_coeffs(esc_pkg::CFG_PRESS_LOW, TYP_PLOW & ~64'hFFFF);
                    write_coeffs(esc_pkg::CFG_HUM,
                                 {8'h80, 12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF});
                end
                default: load_typical();
            endcase
            rx_quiet = (ph == 2);
            tx_quiet = (ph == 2);
            random_burst(100);
        end
        rx_quiet = 1'b0;
        tx_quiet = 1'b0;

        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
